// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted
`define RSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that a condition never holds
`define RSC_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/rsc_pkg.sv
// Types and constants of the row standardiser
package rsc_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_EN   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_EN  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MAX   = 8'd3;

    localparam logic [15:0] ROW_LENGTH_RST = 16'd2;
    localparam logic [23:0] CLIP_MAX_RST   = 24'd655360;

    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd127;
    localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd31;
    localparam logic [CNT_W-1:0] MULN_STEPS = 7'd15;
    localparam logic [CNT_W-1:0] MULM_STEPS = 7'd39;

    typedef enum logic [4:0] {
        S_IDLE,
        S_GATHER_ACC,
        S_MEAN_LOAD,
        S_MEAN_DIV,
        S_MEAN_END,
        S_MULN_LOAD,
        S_MULN,
        S_MULN_END,
        S_MULM_LOAD,
        S_MULM,
        S_VAR_LOAD,
        S_VAR_DIV,
        S_VAR_END,
        S_SQRT,
        S_INV_LOAD,
        S_INV_DIV,
        S_INV_END,
        S_SCALE_MUL,
        S_SCALE_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_ACCUM,
        OP_MEAN_LOAD,
        OP_DIV_STEP,
        OP_MEAN_END,
        OP_MULN_LOAD,
        OP_MUL_STEP,
        OP_MULN_END,
        OP_MULM_LOAD,
        OP_VAR_LOAD,
        OP_VAR_END,
        OP_SQRT_STEP,
        OP_INV_LOAD,
        OP_INV_END,
        OP_SCALE_MUL
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_en;
    } t_dp_cmd;

    typedef struct packed {
        logic stats_ready;
    } t_dp_status;

    typedef struct packed {
        logic [15:0] row_length;
        logic        scale_enable;
        logic        center_enable;
        logic [23:0] clip_max;
    } t_cfg;

endpackage

// File: hw/rtl/rsc_cfg.sv
// Configuration register file of the row standardiser
module rsc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rsc_pkg::t_cfg                 o_cfg
);
    import rsc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_length    <= ROW_LENGTH_RST;
            r_cfg.scale_enable  <= 1'b1;
            r_cfg.center_enable <= 1'b1;
            r_cfg.clip_max      <= CLIP_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_LENGTH: r_cfg.row_length    <= i_cfg_data[15:0];
                CFG_SCALE_EN:   r_cfg.scale_enable  <= i_cfg_data[0];
                CFG_CENTER_EN:  r_cfg.center_enable <= i_cfg_data[0];
                CFG_CLIP_MAX:   r_cfg.clip_max      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/rsc_ctrl.sv
// Controller state machine of the row standardiser
`include "assert_macros.svh"
module rsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_kind,
    input  rsc_pkg::t_cfg       i_cfg,
    input  rsc_pkg::t_dp_status i_status,
    output rsc_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);
    import rsc_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and loop counter
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (!i_kind) begin
                        n_state = S_GATHER_ACC;
                    end else if (i_status.stats_ready) begin
                        n_state = S_SCALE_MUL;
                    end else begin
                        n_state = S_MEAN_LOAD;
                    end
                end
            end
            S_GATHER_ACC: n_state = S_IDLE;
            S_MEAN_LOAD:  n_state = S_MEAN_DIV;
            S_MEAN_DIV: begin
                if (r_cnt == DIV_STEPS) begin
                    n_state = S_MEAN_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MEAN_END: begin
                if (!i_cfg.scale_enable) begin
                    n_state = S_SCALE_MUL;
                end else if (i_cfg.center_enable) begin
                    n_state = S_MULN_LOAD;
                end else begin
                    n_state = S_VAR_LOAD;
                end
            end
            S_MULN_LOAD: n_state = S_MULN;
            S_MULN: begin
                if (r_cnt == MULN_STEPS) begin
                    n_state = S_MULN_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MULN_END:  n_state = S_MULM_LOAD;
            S_MULM_LOAD: n_state = S_MULM;
            S_MULM: begin
                if (r_cnt == MULM_STEPS) begin
                    n_state = S_VAR_LOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_VAR_LOAD: n_state = S_VAR_DIV;
            S_VAR_DIV: begin
                if (r_cnt == DIV_STEPS) begin
                    n_state = S_VAR_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_VAR_END: n_state = S_SQRT;
            S_SQRT: begin
                if (r_cnt == SQRT_STEPS) begin
                    n_state = S_INV_LOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_INV_LOAD: n_state = S_INV_DIV;
            S_INV_DIV: begin
                if (r_cnt == DIV_STEPS) begin
                    n_state = S_INV_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_INV_END:   n_state = S_SCALE_MUL;
            S_SCALE_MUL: n_state = S_SCALE_OUT;
            S_SCALE_OUT: n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd.op     = OP_NONE;
        o_cmd.out_en = 1'b0;
        case (r_state)
            S_IDLE:       o_cmd.op = accept ? OP_LATCH : OP_NONE;
            S_GATHER_ACC: o_cmd.op = OP_ACCUM;
            S_MEAN_LOAD:  o_cmd.op = OP_MEAN_LOAD;
            S_MEAN_DIV:   o_cmd.op = OP_DIV_STEP;
            S_MEAN_END:   o_cmd.op = OP_MEAN_END;
            S_MULN_LOAD:  o_cmd.op = OP_MULN_LOAD;
            S_MULN:       o_cmd.op = OP_MUL_STEP;
            S_MULN_END:   o_cmd.op = OP_MULN_END;
            S_MULM_LOAD:  o_cmd.op = OP_MULM_LOAD;
            S_MULM:       o_cmd.op = OP_MUL_STEP;
            S_VAR_LOAD:   o_cmd.op = OP_VAR_LOAD;
            S_VAR_DIV:    o_cmd.op = OP_DIV_STEP;
            S_VAR_END:    o_cmd.op = OP_VAR_END;
            S_SQRT:       o_cmd.op = OP_SQRT_STEP;
            S_INV_LOAD:   o_cmd.op = OP_INV_LOAD;
            S_INV_DIV:    o_cmd.op = OP_DIV_STEP;
            S_INV_END:    o_cmd.op = OP_INV_END;
            S_SCALE_MUL:  o_cmd.op = OP_SCALE_MUL;
            S_SCALE_OUT:  o_cmd.out_en = 1'b1;
            default:      o_cmd.op = OP_NONE;
        endcase
    end

    `RSC_ASSERT(a_gather_path, (accept && !i_kind) |=> (r_state == S_GATHER_ACC),
        "gather request did not go to accumulation")
    `RSC_ASSERT(a_scale_path, (accept && i_kind) |=>
        (r_state == S_SCALE_MUL || r_state == S_MEAN_LOAD), "scale request misrouted")
    `RSC_ASSERT(a_out_once, (r_state == S_SCALE_OUT) |=> (r_state == S_IDLE),
        "result stage did not return to idle")

endmodule

// File: hw/rtl/rsc_dp.sv
// Datapath of the row standardiser: accumulators, serial multiplier, divider, root
`include "assert_macros.svh"
module rsc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsc_pkg::t_dp_cmd    i_cmd,
    input  rsc_pkg::t_cfg       i_cfg,
    input  logic signed [23:0]  i_value,
    input  logic                i_last,
    output rsc_pkg::t_dp_status o_status,
    output logic                o_valid,
    output logic signed [31:0]  o_scaled,
    output logic                o_zero_spread,
    output logic                o_row_end
);
    import rsc_pkg::*;

    logic [39:0]  r_vsum;
    logic [63:0]  r_ssum;
    logic [23:0]  r_mean;
    logic [31:0]  r_inv;
    logic         r_ready;
    logic [23:0]  r_x;
    logic         r_last;
    logic [47:0]  r_sq;
    logic [39:0]  r_mag;
    logic         r_mneg;
    logic [127:0] r_dnum;
    logic [63:0]  r_drem;
    logic [63:0]  r_dq;
    logic [63:0]  r_dden;
    logic [79:0]  r_macc;
    logic [79:0]  r_mcand;
    logic [39:0]  r_mplier;
    logic [79:0]  r_a;
    logic [63:0]  r_sv;
    logic [63:0]  r_sres;
    logic [63:0]  r_sbit;
    logic [56:0]  r_prod;
    logic         r_dneg;
    logic         r_valid;
    logic [31:0]  r_scaled;
    logic         r_zero;
    logic         r_rend;

    logic [15:0]  n_len;
    logic [39:0]  vmag;
    logic [63:0]  rem_sh;
    logic         div_take;
    logic [63:0]  sq_try;
    logic signed [24:0] dval;
    logic [24:0]  dmag;
    logic [57:0]  rnd;
    logic signed [42:0] res;
    logic signed [42:0] cm;
    logic [31:0]  sat_res;
    logic [31:0]  nn1;

    assign n_len = (i_cfg.row_length < 16'd2) ? 16'd2 : i_cfg.row_length;
    assign vmag  = r_vsum[39] ? (~r_vsum + 40'd1) : r_vsum;
    assign rem_sh = {r_drem[62:0], r_dnum[127]};
    assign div_take = r_drem[63] || (rem_sh >= r_dden);
    assign sq_try = r_sres + r_sbit;
    assign dval = {r_x[23], r_x} - {r_mean[23], r_mean};
    assign dmag = dval[24] ? (~dval + 25'sd1) : dval;
    assign nn1 = n_len * (n_len - 16'd1);

    // round, clip above, then saturate
    always_comb begin
        rnd = {1'b0, r_prod} + 58'd32768;
        res = r_dneg ? -$signed({1'b0, rnd[57:16]}) : $signed({1'b0, rnd[57:16]});
        cm  = 43'(signed'(i_cfg.clip_max));
        if (res > cm) begin
            res = cm;
        end
        if (res > 43'sd2147483647) begin
            sat_res = 32'h7FFF_FFFF;
        end else if (res < -43'sd2147483648) begin
            sat_res = 32'h8000_0000;
        end else begin
            sat_res = res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsum  <= '0;
            r_ssum  <= '0;
            r_mean  <= '0;
            r_inv   <= '0;
            r_ready <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_en;
            case (i_cmd.op)
                OP_ACCUM: begin
                    r_vsum <= r_vsum + {{16{r_x[23]}}, r_x};
                    r_ssum <= r_ssum + {16'd0, r_sq};
                end
                OP_MEAN_END: begin
                    if (!i_cfg.center_enable) begin
                        r_mean <= '0;
                    end else if (!r_mneg) begin
                        r_mean <= (r_dq > 64'd8388607) ? 24'h7FFFFF : r_dq[23:0];
                    end else begin
                        r_mean <= (r_dq > 64'd8388608) ? 24'h800000 : (~r_dq[23:0] + 24'd1);
                    end
                    if (!i_cfg.scale_enable) begin
                        r_inv <= 32'd65536;
                    end
                end
                OP_INV_END: begin
                    if (r_sres == 64'd0) begin
                        r_inv <= '0;
                    end else if (r_dq > 64'hFFFF_FFFF) begin
                        r_inv <= 32'hFFFF_FFFF;
                    end else begin
                        r_inv <= r_dq[31:0];
                    end
                end
                OP_SCALE_MUL: r_ready <= 1'b1;
                default: ;
            endcase
            // a row end clears the accumulators
            if (i_cmd.out_en && r_last) begin
                r_vsum  <= '0;
                r_ssum  <= '0;
                r_ready <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_x    <= i_value;
                r_last <= i_last;
                r_sq   <= 48'(i_value * i_value);
            end
            OP_MEAN_LOAD: begin
                r_mag  <= vmag;
                r_mneg <= r_vsum[39];
                r_dnum <= {87'd0, {1'b0, vmag} + {26'd0, n_len[15:1]}};
                r_dden <= {48'd0, n_len};
                r_drem <= '0;
                r_dq   <= '0;
            end
            OP_DIV_STEP: begin
                r_dnum <= {r_dnum[126:0], 1'b0};
                if (div_take) begin
                    r_drem <= rem_sh - r_dden;
                    r_dq   <= {r_dq[62:0], 1'b1};
                end else begin
                    r_drem <= rem_sh;
                    r_dq   <= {r_dq[62:0], 1'b0};
                end
            end
            OP_MULN_LOAD: begin
                r_macc   <= '0;
                r_mcand  <= {16'd0, r_ssum};
                r_mplier <= {24'd0, n_len};
            end
            OP_MUL_STEP: begin
                if (r_mplier[0]) begin
                    r_macc <= r_macc + r_mcand;
                end
                r_mcand  <= {r_mcand[78:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[39:1]};
            end
            OP_MULN_END: r_a <= r_macc;
            OP_MULM_LOAD: begin
                r_macc   <= '0;
                r_mcand  <= {40'd0, r_mag};
                r_mplier <= r_mag;
            end
            OP_VAR_LOAD: begin
                r_drem <= '0;
                r_dq   <= '0;
                if (i_cfg.center_enable) begin
                    // a negative numerator counts as zero
                    r_dnum <= (r_macc > r_a) ? '0 : {48'd0, r_a - r_macc};
                    r_dden <= {32'd0, nn1};
                end else begin
                    r_dnum <= {64'd0, r_ssum};
                    r_dden <= {48'd0, n_len - 16'd1};
                end
            end
            OP_VAR_END: begin
                r_sv   <= r_dq;
                r_sres <= '0;
                r_sbit <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT_STEP: begin
                if (r_sv >= sq_try) begin
                    r_sv   <= r_sv - sq_try;
                    r_sres <= {1'b0, r_sres[63:1]} + r_sbit;
                end else begin
                    r_sres <= {1'b0, r_sres[63:1]};
                end
                r_sbit <= {2'b00, r_sbit[63:2]};
            end
            OP_INV_LOAD: begin
                r_dnum <= {64'd0, 64'h1_0000_0000 + {1'b0, r_sres[63:1]}};
                r_dden <= r_sres;
                r_drem <= '0;
                r_dq   <= '0;
            end
            OP_SCALE_MUL: begin
                r_dneg <= dval[24];
                r_prod <= {32'd0, dmag} * {25'd0, r_inv};
            end
            default: ;
        endcase
        if (i_cmd.out_en) begin
            r_zero   <= (r_inv == 32'd0);
            r_scaled <= (r_inv == 32'd0) ? 32'd0 : sat_res;
            r_rend   <= r_last;
        end
    end

    assign o_status.stats_ready = r_ready;
    assign o_valid       = r_valid;
    assign o_scaled      = r_scaled;
    assign o_zero_spread = r_zero;
    assign o_row_end     = r_rend;

    `RSC_ASSERT(a_ready_at_out, i_cmd.out_en |-> r_ready,
        "result formed before statistics were ready")
    `RSC_ASSERT(a_strobe_single, r_valid |=> !r_valid, "result strobe held for two cycles")
    `RSC_ASSERT(a_strobe_src, r_valid |-> $past(i_cmd.out_en),
        "result strobe without a result stage")

endmodule

// File: hw/rtl/row_standardize_clip.sv
// Top level of the row standardiser
//
//  channel  | handshake                  | payload
//  request  | i_start / o_busy           | i_kind, i_value, i_last
//  result   | o_valid (one cycle strobe) | o_scaled, o_zero_spread, o_row_end
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A gather request is accumulated and the block returns to idle. A scale request
// forms its result from the row statistics; the first scale request of a row also
// forms them: with scaling off only the mean, else also the variance, its root and
// the inverse, the shift-add multiplier first forming the centred sums if centring
// is on; the divider is bit-serial (128 steps a use), the root has 32 steps.
// Reset is synchronous; it clears the accumulators and restores the registers.
// The receiver cannot stall: each result is shown for one cycle only.
module row_standardize_clip (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_kind,
    input  logic signed [23:0]            i_value,
    input  logic                          i_last,
    output logic                          o_valid,
    output logic signed [31:0]            o_scaled,
    output logic                          o_zero_spread,
    output logic                          o_row_end,
    input  logic                          i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rsc_pkg::*;

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    rsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_kind   (i_kind),
        .i_cfg    (cfg),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    rsc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_value       (i_value),
        .i_last        (i_last),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_scaled      (o_scaled),
        .o_zero_spread (o_zero_spread),
        .o_row_end     (o_row_end)
    );

endmodule

// File: sim/rsc_checker.sv
// Checker for the row standardiser: watches the ports, predicts results and compares
`timescale 1ns / 1ps

module rsc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic                           i_kind,
    input  logic signed [23:0]             i_value,
    input  logic                           i_last,
    input  logic                           i_valid,
    input  logic signed [31:0]             i_scaled,
    input  logic                           i_zero_spread,
    input  logic                           i_row_end,
    input  logic                           i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_result_count
);
    import rsc_pkg::*;

    typedef struct packed {
        logic signed [31:0] scaled;
        logic               zero_spread;
        logic               row_end;
    } t_zscore;

    t_zscore zscore_q[$];

    // Register copies
    logic [15:0]        len_cfg;
    logic               scale_on;
    logic               center_on;
    logic signed [23:0] clip_lim;

    // Row statistics
    logic [39:0]        acc_sum;
    logic [63:0]        acc_sq;
    logic signed [23:0] mean_q;
    logic [31:0]        inv_sd;
    logic               stats_valid;

    assign o_pending = zscore_q.size();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        o_fail_count++;
        $display("%0t: MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic form_row_stats();
        logic [63:0]        n, mag, qm, var_q, v, res, bitv, inv;
        logic signed [63:0] sum, m;
        logic [127:0]       prod_a, prod_b;
        n = (len_cfg < 16'd2) ? 64'd2 : 64'(len_cfg);
        sum = {{24{acc_sum[39]}}, acc_sum};
        mag = (sum < 0) ? 64'(-sum) : 64'(sum);
        qm = (mag + n / 2) / n;
        m = (sum < 0) ? -$signed(qm) : $signed(qm);
        if (m > 64'sd8388607) m = 64'sd8388607;
        if (m < -64'sd8388608) m = -64'sd8388608;
        mean_q = center_on ? 24'(m) : 24'sd0;
        if (!scale_on) begin
            inv_sd = 32'd65536;
        end else begin
            if (center_on) begin
                prod_a = 128'(n) * 128'(acc_sq);
                prod_b = 128'(mag) * 128'(mag);
                var_q = (prod_b > prod_a) ? 64'd0 : 64'((prod_a - prod_b) / 128'(n * (n - 1)));
            end else begin
                var_q = acc_sq / (n - 1);
            end
            // integer square root, two bits per step
            v = var_q;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            if (res == 0) begin
                inv_sd = 32'd0;
            end else begin
                inv = ((64'd1 << 32) + res / 2) / res;
                inv_sd = (inv > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(inv);
            end
        end
        stats_valid = 1'b1;
    endtask

    task automatic predict_request(input logic kind, input logic signed [23:0] x,
                                   input logic last);
        t_zscore            e;
        logic signed [63:0] d, r, cm;
        logic [63:0]        dm, pm;
        if (kind == 1'b0) begin
            acc_sum = acc_sum + {{16{x[23]}}, x};
            acc_sq = acc_sq + 64'($signed(64'(x)) * $signed(64'(x)));
        end else begin
            if (!stats_valid) form_row_stats();
            if (inv_sd == 0) begin
                e.scaled = 0;
                e.zero_spread = 1'b1;
            end else begin
                d = 64'(x) - 64'(mean_q);
                dm = (d < 0) ? 64'(-d) : 64'(d);
                pm = (dm * 64'(inv_sd) + 64'd32768) >> 16;
                r = (d < 0) ? -$signed(pm) : $signed(pm);
                cm = 64'(clip_lim);
                if (r > cm) r = cm;
                if (r < -64'sd2147483648) r = -64'sd2147483648;
                if (r > 64'sd2147483647) r = 64'sd2147483647;
                e.scaled = 32'(r);
                e.zero_spread = 1'b0;
            end
            e.row_end = last;
            zscore_q.push_back(e);
            if (last) begin
                acc_sum = 0;
                acc_sq = 0;
                stats_valid = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_zscore e;
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_result_count = 0;
            len_cfg = ROW_LENGTH_RST;
            scale_on = 1'b1;
            center_on = 1'b1;
            clip_lim = CLIP_MAX_RST;
            acc_sum = 0;
            acc_sq = 0;
            mean_q = 0;
            inv_sd = 0;
            stats_valid = 1'b0;
        end else begin
            // results first: a result at this edge belongs to an earlier request
            if (i_valid) begin
                o_result_count++;
                if (zscore_q.size() == 0) begin
                    report_mismatch("unexpected result", i_scaled, 0);
                end else begin
                    e = zscore_q.pop_front();
                    if (i_scaled !== e.scaled)
                        report_mismatch("scaled", i_scaled, e.scaled);
                    if (i_zero_spread !== e.zero_spread)
                        report_mismatch("zero_spread", i_zero_spread, e.zero_spread);
                    if (i_row_end !== e.row_end)
                        report_mismatch("row_end", i_row_end, e.row_end);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_LENGTH: len_cfg = i_cfg_data[15:0];
                    CFG_SCALE_EN:   scale_on = i_cfg_data[0];
                    CFG_CENTER_EN:  center_on = i_cfg_data[0];
                    CFG_CLIP_MAX:   clip_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) predict_request(i_kind, i_value, i_last);
        end
    end

endmodule

// File: sim/testbench.sv
// Top of the row standardiser testbench: stimulus, register settings and verdict
`timescale 1ns / 1ps

module testbench;
    import rsc_pkg::*;

    localparam logic KIND_GATHER = 1'b0;
    localparam logic KIND_SCALE  = 1'b1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  i_kind = 1'b0;
    logic signed [23:0]    i_value = '0;
    logic                  i_last = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_busy, o_valid, o_zero_spread, o_row_end;
    logic signed [31:0]    o_scaled;
    int                    fail_count, pending, result_count;
    int                    request_count = 0, row_count = 0, setting_count = 0, burst_left = 0;

    row_standardize_clip uut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_kind, .i_value, .i_last,
        .o_valid, .o_scaled, .o_zero_spread, .o_row_end,
        .i_cfg_we, .i_cfg_index, .i_cfg_data
    );

    rsc_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_kind, .i_value, .i_last,
        .i_valid(o_valid), .i_scaled(o_scaled), .i_zero_spread(o_zero_spread),
        .i_row_end(o_row_end), .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hold start high across a burst; drop it only for a gap
    task automatic send_request(input logic kind, input logic signed [23:0] v,
                                input logic last);
        if (burst_left == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
        end
        i_start <= 1'b1;
        i_kind <= kind;
        i_value <= v;
        i_last <= last;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        burst_left--;
        request_count++;
    endtask

    // Drain outstanding results, then let a trailing gather finish
    task automatic settle();
        i_start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] len, input logic sc, input logic ce,
                                 input logic [23:0] clip);
        settle();
        // upper data bits are junk on purpose; the block masks them
        write_reg(CFG_ROW_LENGTH, CFG_DATA_W'({$urandom_range(0, 255), len}));
        write_reg(CFG_SCALE_EN, CFG_DATA_W'({$urandom, sc}));
        write_reg(CFG_CENTER_EN, CFG_DATA_W'({$urandom, ce}));
        write_reg(CFG_CLIP_MAX, clip);
        write_reg(CFG_IDX_W'(4 + $urandom_range(0, 250)), CFG_DATA_W'($urandom));
        setting_count++;
    endtask

    function automatic logic signed [23:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 24'sh7FFFFF;
            1:       return -24'sh800000;
            2:       return 24'sd0;
            3, 4:    return 24'($signed($urandom_range(0, 131071)) - 65536);
            5:       return 24'($signed($urandom_range(0, 4095)) - 2048);
            default: return 24'($urandom);
        endcase
    endfunction

    // One well-formed row, occasionally broken: skipped zeros, stray last, late gathers
    task automatic run_row(input int n);
        logic signed [23:0] v;
        int scales;
        for (int k = 0; k < n; k++) begin
            v = pick_value();
            if (v == 0 && $urandom_range(0, 1)) continue;
            send_request(KIND_GATHER, v, $urandom_range(0, 15) == 0);
        end
        scales = $urandom_range(1, n + 1);
        for (int k = 0; k < scales; k++) begin
            if ($urandom_range(0, 19) == 0) send_request(KIND_GATHER, pick_value(), 1'b0);
            send_request(KIND_SCALE, pick_value(), k == scales - 1);
        end
        row_count++;
    endtask

    initial begin
        logic [15:0] len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: scale without gather, extremes, stray last, gather after scale
        send_request(KIND_SCALE, 24'sd100, 1'b1);
        send_request(KIND_GATHER, 24'sh7FFFFF, 1'b0);
        send_request(KIND_GATHER, -24'sh800000, 1'b1);
        send_request(KIND_GATHER, 24'sd0, 1'b0);
        send_request(KIND_SCALE, 24'sh7FFFFF, 1'b0);
        send_request(KIND_GATHER, 24'sd65536, 1'b0);
        send_request(KIND_SCALE, -24'sh800000, 1'b0);
        send_request(KIND_SCALE, 24'sd0, 1'b1);
        send_request(KIND_GATHER, 24'sd65536, 1'b0);
        send_request(KIND_GATHER, 24'sd65536, 1'b0);
        send_request(KIND_SCALE, 24'sd65536, 1'b1);
        apply_setting(16'd0, 1'b1, 1'b0, 24'h7FFFFF);
        send_request(KIND_GATHER, -24'sh800000, 1'b0);
        send_request(KIND_GATHER, 24'sh7FFFFF, 1'b0);
        send_request(KIND_SCALE, 24'sh7FFFFF, 1'b0);
        send_request(KIND_SCALE, -24'sh800000, 1'b1);
        apply_setting(16'hFFFF, 1'b0, 1'b1, 24'h800000);
        send_request(KIND_GATHER, 24'sh7FFFFF, 1'b0);
        send_request(KIND_SCALE, 24'sh7FFFFF, 1'b0);
        send_request(KIND_SCALE, -24'sh800000, 1'b1);
        apply_setting(16'd3, 1'b0, 1'b0, 24'h000000);
        send_request(KIND_SCALE, 24'sh7FFFFF, 1'b0);
        send_request(KIND_SCALE, -24'sh800000, 1'b1);

        // Random rows, with a fresh register setting every few rows
        while (request_count < 1450) begin
            case ($urandom_range(0, 5))
                0:       len = 16'hFFFF;
                1:       len = 16'($urandom_range(0, 1));
                default: len = 16'($urandom_range(2, 12));
            endcase
            apply_setting(len, $urandom_range(0, 4) != 0, $urandom_range(0, 3) != 0,
                          ($urandom_range(0, 2) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(65536, 1048576)));
            repeat ($urandom_range(3, 8)) begin
                run_row((len < 2 || len > 12) ? $urandom_range(1, 12)
                        : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : int'(len)));
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests in %0d rows over %0d register settings", request_count,
                 row_count, setting_count);
        $display("Checked %0d results", result_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
